// ===== design/clt_pkg.sv =====
// Shared types and constants of the C-style lexer tokenizer.
// No dependencies; the scanner, the tokenizer top and the testbench refer to this package.
package clt_pkg;

    // Width of the running byte offset; token offsets are its low 16 bits.
    localparam int POS_BITS = 16;

    typedef enum logic [5:0] {
        TK_WORD, TK_NUMBER, TK_STRING,
        TK_PLUS, TK_INC, TK_PLUS_EQ, TK_MINUS, TK_DEC, TK_MINUS_EQ, TK_ARROW,
        TK_STAR, TK_STAR_EQ, TK_SLASH, TK_SLASH_EQ, TK_PERCENT, TK_PERCENT_EQ,
        TK_ASSIGN, TK_EQ, TK_NOT, TK_NE, TK_LT, TK_SHL, TK_LE, TK_SHL_EQ,
        TK_SPACESHIP, TK_GT, TK_SHR, TK_GE, TK_SHR_EQ, TK_TILDE, TK_AMP,
        TK_LAND, TK_AMP_EQ, TK_PIPE, TK_LOR, TK_PIPE_EQ, TK_CARET, TK_CARET_EQ,
        TK_DOT, TK_ELLIPSIS, TK_COLON, TK_SCOPE, TK_QUEST, TK_ELVIS,
        TK_LPAREN, TK_RPAREN, TK_LBRACK, TK_RBRACK, TK_LBRACE, TK_RBRACE,
        TK_SEMI, TK_COMMA, TK_ERROR, TK_END
    } tok_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUMBER,
        MODE_STRING
    } mode_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] start;
        logic [15:0] length;
    } res_t;

    // All tokens caused by one input byte.
    typedef struct packed {
        res_t [2:0] res;
        logic [1:0] count;
        logic       ending;
    } batch_t;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UZ      = 8'h5A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LZ      = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

endpackage

// ===== design/clt_if.sv =====
// Valid/ready channel interfaces of the tokenizer: source bytes in, tokens out.
// Standalone; no package dependency.
interface clt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface clt_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
    logic        last_of_text;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last_of_run, output last_of_text,
                    input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, input last_of_text,
                  output ready);
endinterface

// ===== design/clt_scan.sv =====
// Lexer state and the single-pass scan of one byte against the lookahead.
// Depends on clt_pkg.
module clt_scan (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  clt_pkg::item_t  item,
    output clt_pkg::batch_t batch
);

    // Worst case: three bytes popped, three runs closed, one final look.
    localparam int DRAIN_STEPS = 7;

    typedef struct packed {
        logic [7:0]          w0;
        logic [7:0]          w1;
        logic [7:0]          w2;
        logic [1:0]          wn;
        clt_pkg::mode_t      mode;
        logic [7:0]          quote;
        logic [15:0]         cur_start;
        logic [15:0]         cur_len;
        logic                halted;
        logic                done;
        clt_pkg::res_t [2:0] res;
        logic [1:0]          nout;
    } wk_t;

    typedef struct packed {
        logic                ok;
        clt_pkg::tok_kind_t  kind;
        logic [1:0]          len;
    } punct_t;

    logic [7:0]                   la0_reg, la0_next;
    logic [7:0]                   la1_reg, la1_next;
    logic [1:0]                   la_cnt_reg, la_cnt_next;
    clt_pkg::mode_t               mode_reg, mode_next;
    logic [7:0]                   quote_reg, quote_next;
    logic [15:0]                  cur_start_reg, cur_start_next;
    logic [15:0]                  cur_len_reg, cur_len_next;
    logic [clt_pkg::POS_BITS-1:0] bpos_reg, bpos_next;
    logic                         halted_reg, halted_next;

    logic [clt_pkg::POS_BITS-1:0] bpos_new;
    logic                         pushing;
    logic                         ending;
    wk_t                          w;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[clt_pkg::CH_LA:clt_pkg::CH_LZ], [clt_pkg::CH_UA:clt_pkg::CH_UZ]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[clt_pkg::CH_0:clt_pkg::CH_9]};
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {clt_pkg::CH_SPACE, [clt_pkg::CH_TAB:clt_pkg::CH_CR]};
    endfunction

    // Punctuators decided by their first byte alone.
    function automatic logic is_single(input logic [7:0] c);
        return c inside {clt_pkg::CH_TILDE, clt_pkg::CH_LPAREN, clt_pkg::CH_RPAREN,
                         clt_pkg::CH_LBRACK, clt_pkg::CH_RBRACK, clt_pkg::CH_LBRACE,
                         clt_pkg::CH_RBRACE, clt_pkg::CH_SEMI, clt_pkg::CH_COMMA};
    endfunction

    // Punctuators that need the third byte once the second is known.
    function automatic logic is_deep(input logic [7:0] c, input logic [7:0] a);
        return (c == clt_pkg::CH_LT && (a == clt_pkg::CH_LT || a == clt_pkg::CH_EQUAL))
            || (c == clt_pkg::CH_GT && a == clt_pkg::CH_GT)
            || (c == clt_pkg::CH_DOT && a == clt_pkg::CH_DOT);
    endfunction

    function automatic punct_t pick(input logic hit, input clt_pkg::tok_kind_t two,
                                    input clt_pkg::tok_kind_t one);
        punct_t p;
        p.ok   = 1'b1;
        p.kind = hit ? two : one;
        p.len  = hit ? 2'd2 : 2'd1;
        return p;
    endfunction

    function automatic punct_t punct_decode(input logic [7:0] x, input logic [7:0] a,
                                            input logic [7:0] b);
        punct_t p;
        p.ok   = 1'b1;
        p.kind = clt_pkg::TK_ERROR;
        p.len  = 2'd1;
        case (x)
            clt_pkg::CH_PLUS:
                if (a == clt_pkg::CH_PLUS) p = pick(1'b1, clt_pkg::TK_INC, clt_pkg::TK_PLUS);
                else p = pick(a == clt_pkg::CH_EQUAL, clt_pkg::TK_PLUS_EQ, clt_pkg::TK_PLUS);
            clt_pkg::CH_MINUS:
                if (a == clt_pkg::CH_MINUS) p = pick(1'b1, clt_pkg::TK_DEC, clt_pkg::TK_MINUS);
                else if (a == clt_pkg::CH_EQUAL)
                    p = pick(1'b1, clt_pkg::TK_MINUS_EQ, clt_pkg::TK_MINUS);
                else p = pick(a == clt_pkg::CH_GT, clt_pkg::TK_ARROW, clt_pkg::TK_MINUS);
            clt_pkg::CH_STAR:
                p = pick(a == clt_pkg::CH_EQUAL, clt_pkg::TK_STAR_EQ, clt_pkg::TK_STAR);
            clt_pkg::CH_SLASH:
                p = pick(a == clt_pkg::CH_EQUAL, clt_pkg::TK_SLASH_EQ, clt_pkg::TK_SLASH);
            clt_pkg::CH_PERCENT:
                p = pick(a == clt_pkg::CH_EQUAL, clt_pkg::TK_PERCENT_EQ, clt_pkg::TK_PERCENT);
            clt_pkg::CH_EQUAL:
                p = pick(a == clt_pkg::CH_EQUAL, clt_pkg::TK_EQ, clt_pkg::TK_ASSIGN);
            clt_pkg::CH_BANG:
                p = pick(a == clt_pkg::CH_EQUAL, clt_pkg::TK_NE, clt_pkg::TK_NOT);
            clt_pkg::CH_LT:
                if (a == clt_pkg::CH_LT && b == clt_pkg::CH_EQUAL) begin
                    p.kind = clt_pkg::TK_SHL_EQ;
                    p.len  = 2'd3;
                end else if (a == clt_pkg::CH_EQUAL && b == clt_pkg::CH_GT) begin
                    p.kind = clt_pkg::TK_SPACESHIP;
                    p.len  = 2'd3;
                end else if (a == clt_pkg::CH_LT) p = pick(1'b1, clt_pkg::TK_SHL, clt_pkg::TK_LT);
                else p = pick(a == clt_pkg::CH_EQUAL, clt_pkg::TK_LE, clt_pkg::TK_LT);
            clt_pkg::CH_GT:
                if (a == clt_pkg::CH_GT && b == clt_pkg::CH_EQUAL) begin
                    p.kind = clt_pkg::TK_SHR_EQ;
                    p.len  = 2'd3;
                end else if (a == clt_pkg::CH_GT) p = pick(1'b1, clt_pkg::TK_SHR, clt_pkg::TK_GT);
                else p = pick(a == clt_pkg::CH_EQUAL, clt_pkg::TK_GE, clt_pkg::TK_GT);
            clt_pkg::CH_TILDE:  p.kind = clt_pkg::TK_TILDE;
            clt_pkg::CH_AMP:
                if (a == clt_pkg::CH_AMP) p = pick(1'b1, clt_pkg::TK_LAND, clt_pkg::TK_AMP);
                else p = pick(a == clt_pkg::CH_EQUAL, clt_pkg::TK_AMP_EQ, clt_pkg::TK_AMP);
            clt_pkg::CH_PIPE:
                if (a == clt_pkg::CH_PIPE) p = pick(1'b1, clt_pkg::TK_LOR, clt_pkg::TK_PIPE);
                else p = pick(a == clt_pkg::CH_EQUAL, clt_pkg::TK_PIPE_EQ, clt_pkg::TK_PIPE);
            clt_pkg::CH_CARET:
                p = pick(a == clt_pkg::CH_EQUAL, clt_pkg::TK_CARET_EQ, clt_pkg::TK_CARET);
            clt_pkg::CH_DOT:
                if (a == clt_pkg::CH_DOT && b == clt_pkg::CH_DOT) begin
                    p.kind = clt_pkg::TK_ELLIPSIS;
                    p.len  = 2'd3;
                end else p.kind = clt_pkg::TK_DOT;
            clt_pkg::CH_COLON:
                p = pick(a == clt_pkg::CH_COLON, clt_pkg::TK_SCOPE, clt_pkg::TK_COLON);
            clt_pkg::CH_QUEST:
                p = pick(a == clt_pkg::CH_COLON, clt_pkg::TK_ELVIS, clt_pkg::TK_QUEST);
            clt_pkg::CH_LPAREN: p.kind = clt_pkg::TK_LPAREN;
            clt_pkg::CH_RPAREN: p.kind = clt_pkg::TK_RPAREN;
            clt_pkg::CH_LBRACK: p.kind = clt_pkg::TK_LBRACK;
            clt_pkg::CH_RBRACK: p.kind = clt_pkg::TK_RBRACK;
            clt_pkg::CH_LBRACE: p.kind = clt_pkg::TK_LBRACE;
            clt_pkg::CH_RBRACE: p.kind = clt_pkg::TK_RBRACE;
            clt_pkg::CH_SEMI:   p.kind = clt_pkg::TK_SEMI;
            clt_pkg::CH_COMMA:  p.kind = clt_pkg::TK_COMMA;
            default:            p.ok = 1'b0;
        endcase
        return p;
    endfunction

    function automatic logic [15:0] to_off(input logic [clt_pkg::POS_BITS-1:0] pos);
        logic [31:0] wide;
        wide = 32'(pos);
        return wide[15:0];
    endfunction

    // Tokens beyond the third of one byte are dropped.
    function automatic wk_t push_token(input wk_t wi, input clt_pkg::tok_kind_t k,
                                       input logic [15:0] s, input logic [15:0] l);
        wk_t r;
        r = wi;
        if (wi.nout != 2'd3) begin
            r.res[wi.nout] = '{kind: k, start: s, length: l};
            r.nout = wi.nout + 2'd1;
        end
        return r;
    endfunction

    function automatic wk_t pop(input wk_t wi, input logic [1:0] k);
        wk_t        r;
        logic [1:0] n;
        r = wi;
        n = (k > wi.wn) ? wi.wn : k;
        case (n)
            2'd1:
            begin
                r.w0 = wi.w1;
                r.w1 = wi.w2;
                r.w2 = '0;
            end
            2'd2:
            begin
                r.w0 = wi.w2;
                r.w1 = '0;
                r.w2 = '0;
            end
            2'd3:
            begin
                r.w0 = '0;
                r.w1 = '0;
                r.w2 = '0;
            end
            default: ;
        endcase
        r.wn = wi.wn - n;
        return r;
    endfunction

    function automatic wk_t start_run(input wk_t wi, input clt_pkg::mode_t m,
                                      input logic [15:0] s, input logic [1:0] k);
        wk_t r;
        r = wi;
        r.mode      = m;
        r.cur_start = s;
        r.cur_len   = 16'(k);
        return pop(r, k);
    endfunction

    function automatic wk_t drain_step(input wk_t wi, input logic fin,
                                       input logic [clt_pkg::POS_BITS-1:0] bp);
        wk_t                r;
        logic [7:0]         x;
        logic [7:0]         a;
        logic [7:0]         b;
        logic               have1;
        logic               have2;
        logic               ext;
        logic               close;
        logic [15:0]        front;
        clt_pkg::tok_kind_t k;
        punct_t             p;
        r     = wi;
        x     = wi.w0;
        a     = (wi.wn > 2'd1) ? wi.w1 : '0;
        b     = (wi.wn > 2'd2) ? wi.w2 : '0;
        have1 = (wi.wn > 2'd1) || fin;
        have2 = (wi.wn > 2'd2) || fin;
        front = to_off(bp - clt_pkg::POS_BITS'(wi.wn));
        p     = punct_decode(x, a, b);
        ext   = 1'b0;
        close = 1'b0;
        case (wi.mode)
            clt_pkg::MODE_WORD:
            begin
                k   = clt_pkg::TK_WORD;
                ext = is_letter(x) || is_digit(x) || x == clt_pkg::CH_UNDER;
            end
            clt_pkg::MODE_NUMBER:
            begin
                k   = clt_pkg::TK_NUMBER;
                ext = is_letter(x) || is_digit(x) || x == clt_pkg::CH_DOT;
            end
            default:
            begin
                k     = clt_pkg::TK_STRING;
                ext   = 1'b1;
                close = (x == wi.quote);
            end
        endcase

        if (!wi.done) begin
            if (wi.halted) begin
                r.wn   = '0;
                r.done = 1'b1;
            end else if (wi.mode != clt_pkg::MODE_IDLE) begin
                if (wi.wn == 2'd0) begin
                    if (fin) begin
                        r      = push_token(r, k, wi.cur_start, wi.cur_len);
                        r.mode = clt_pkg::MODE_IDLE;
                    end
                    r.done = 1'b1;
                end else if (ext) begin
                    if (wi.cur_len != 16'hFFFF) r.cur_len = wi.cur_len + 16'd1;
                    r = pop(r, 2'd1);
                    if (close) begin
                        r      = push_token(r, k, wi.cur_start, r.cur_len);
                        r.mode = clt_pkg::MODE_IDLE;
                    end
                end else begin
                    r      = push_token(r, k, wi.cur_start, wi.cur_len);
                    r.mode = clt_pkg::MODE_IDLE;
                end
            end else if (wi.wn == 2'd0) begin
                r.done = 1'b1;
            end else if (is_blank(x)) begin
                r = pop(r, 2'd1);
            end else if (is_letter(x)) begin
                r = start_run(r, clt_pkg::MODE_WORD, front, 2'd1);
            end else if (is_digit(x)) begin
                r = start_run(r, clt_pkg::MODE_NUMBER, front, 2'd1);
            end else if (x == clt_pkg::CH_DQUOTE || x == clt_pkg::CH_SQUOTE) begin
                r.quote = x;
                r       = start_run(r, clt_pkg::MODE_STRING, front, 2'd1);
            end else if (!p.ok) begin
                r        = push_token(r, clt_pkg::TK_ERROR, front, 16'd1);
                r.halted = 1'b1;
                r.wn     = '0;
                r.done   = 1'b1;
            end else if (!is_single(x) && !have1) begin
                r.done = 1'b1;
            end else if (x == clt_pkg::CH_DOT && is_digit(a)) begin
                r = start_run(r, clt_pkg::MODE_NUMBER, front, 2'd2);
            end else if (is_deep(x, a) && !have2) begin
                r.done = 1'b1;
            end else begin
                r = push_token(r, p.kind, front, 16'(p.len));
                r = pop(r, p.len);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        pushing  = !halted_reg && item.text_byte != clt_pkg::CH_NUL;
        ending   = item.text_byte == clt_pkg::CH_NUL || item.end_of_text;
        bpos_new = pushing ? bpos_reg + clt_pkg::POS_BITS'(1) : bpos_reg;

        w           = '0;
        w.mode      = mode_reg;
        w.quote     = quote_reg;
        w.cur_start = cur_start_reg;
        w.cur_len   = cur_len_reg;
        w.halted    = halted_reg;
        w.wn        = (la_cnt_reg > 2'd2) ? 2'd2 : la_cnt_reg;
        if (w.wn != 2'd0) w.w0 = la0_reg;
        if (w.wn > 2'd1) w.w1 = la1_reg;
        if (pushing) begin
            case (w.wn)
                2'd0:    w.w0 = item.text_byte;
                2'd1:    w.w1 = item.text_byte;
                default: w.w2 = item.text_byte;
            endcase
            w.wn = w.wn + 2'd1;
        end

        for (int i = 0; i < DRAIN_STEPS; i++) begin
            w = drain_step(w, ending, bpos_new);
        end

        if (item.text_byte == clt_pkg::CH_NUL || (ending && w.nout == 2'd0))
            w = push_token(w, clt_pkg::TK_END, to_off(bpos_new), 16'd0);

        batch.res    = w.res;
        batch.count  = w.nout;
        batch.ending = ending;

        if (ending) begin
            la0_next       = '0;
            la1_next       = '0;
            la_cnt_next    = '0;
            mode_next      = clt_pkg::MODE_IDLE;
            quote_next     = '0;
            cur_start_next = '0;
            cur_len_next   = '0;
            bpos_next      = '0;
            halted_next    = 1'b0;
        end else begin
            la0_next       = w.w0;
            la1_next       = w.w1;
            la_cnt_next    = (w.wn > 2'd2) ? 2'd2 : w.wn;
            mode_next      = w.mode;
            quote_next     = w.quote;
            cur_start_next = w.cur_start;
            cur_len_next   = w.cur_len;
            bpos_next      = bpos_new;
            halted_next    = w.halted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            la0_reg       <= '0;
            la1_reg       <= '0;
            la_cnt_reg    <= '0;
            mode_reg      <= clt_pkg::MODE_IDLE;
            quote_reg     <= '0;
            cur_start_reg <= '0;
            cur_len_reg   <= '0;
            bpos_reg      <= '0;
            halted_reg    <= 1'b0;
        end else if (take) begin
            la0_reg       <= la0_next;
            la1_reg       <= la1_next;
            la_cnt_reg    <= la_cnt_next;
            mode_reg      <= mode_next;
            quote_reg     <= quote_next;
            cur_start_reg <= cur_start_next;
            cur_len_reg   <= cur_len_next;
            bpos_reg      <= bpos_next;
            halted_reg    <= halted_next;
        end
    end

endmodule

// ===== design/c_style_lexer_tokenizer.sv =====
// Output: a token is offered in the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle while each byte yields at most one token and the
// sink is ready; a byte yielding n tokens (n up to 3) holds the input until the single
// token register, which hands out one token per transaction, has handed out the last.
// Reset: rst_n asynchronous, active low; clears lexer state and empties the output.
// Depends on clt_pkg, clt_if (channel interfaces) and clt_scan.
module c_style_lexer_tokenizer (
    input  logic         clk,
    input  logic         rst_n,
    clt_char_if.sink     chars,
    clt_token_if.source  tokens
);

    clt_pkg::batch_t scan_batch;
    clt_pkg::batch_t bat_reg;
    clt_pkg::item_t  item;
    clt_pkg::res_t   cur;
    logic            have_reg;
    logic [1:0]      idx_reg;
    logic            take;
    logic            out_take;
    logic            last;

    assign item     = '{text_byte: chars.text_byte, end_of_text: chars.end_of_text};
    assign cur      = bat_reg.res[idx_reg];
    assign last     = (idx_reg == bat_reg.count - 2'd1);
    assign out_take = have_reg && tokens.ready;

    // A new byte may enter as the last pending token leaves.
    assign chars.ready = !have_reg || (tokens.ready && last);
    assign take        = chars.valid && chars.ready;

    clt_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .batch (scan_batch)
    );

    assign tokens.valid        = have_reg;
    assign tokens.token_kind   = cur.kind;
    assign tokens.token_start  = cur.start;
    assign tokens.token_length = cur.length;
    assign tokens.last_of_run  = last;
    assign tokens.last_of_text = last && bat_reg.ending;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            have_reg <= 1'b0;
            idx_reg  <= '0;
            bat_reg  <= '0;
        end else if (take) begin
            have_reg <= (scan_batch.count != 2'd0);
            idx_reg  <= '0;
            bat_reg  <= scan_batch;
        end else if (out_take) begin
            if (last) have_reg <= 1'b0;
            else idx_reg <= idx_reg + 2'd1;
        end
    end

    a_idx_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
        have_reg |-> (idx_reg < bat_reg.count))
        else $error("token index beyond the held batch");

    a_end_gives_token: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (chars.end_of_text || chars.text_byte == clt_pkg::CH_NUL))
        |=> (have_reg && bat_reg.ending))
        else $error("end of text produced no token");

    a_idx_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !last) |=> (have_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("token index did not advance after a transaction");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of c_style_lexer_tokenizer: a queue-fed byte driver, a token
// monitor and a bit-true lexer predictor that checks every token transaction in order.
// Depends on clt_pkg, clt_if (channel interfaces) and the tokenizer RTL.
module tb_top;

    typedef struct {
        clt_pkg::tok_kind_t kind;
        logic [15:0]        start;
        logic [15:0]        length;
        logic               lor;
        logic               lot;
    } tok_exp_t;

    logic clk = 1'b0;
    logic rst_n;

    clt_char_if  chars_if();
    clt_token_if tokens_if();

    c_style_lexer_tokenizer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    always #1 clk = ~clk;

    string punct_list [49] = '{
        "+", "++", "+=", "-", "--", "-=", "->", "*", "*=", "/", "/=", "%", "%=",
        "=", "==", "!", "!=", "<", "<<", "<=", "<<=", "<=>", ">", ">>", ">=", ">>=",
        "~", "&", "&&", "&=", "|", "||", "|=", "^", "^=", ".", "...", ":", "::",
        "?", "?:", "(", ")", "[", "]", "{", "}", ";", ","
    };

    clt_pkg::item_t text_backlog [$];
    tok_exp_t       expected_tokens [$];
    tok_exp_t       step_toks [$];
    tok_exp_t       want;
    clt_pkg::item_t nxt;
    int             src_idle_pct;
    int             snk_idle_pct;
    int             fails = 0;

    // predictor state
    logic [7:0]                   la_bytes [2];
    int unsigned                  la_count;
    clt_pkg::mode_t               scan_st;
    logic [7:0]                   quote_ch;
    logic [clt_pkg::POS_BITS-1:0] tok_start;
    logic [clt_pkg::POS_BITS-1:0] byte_pos;
    bit                           halted;
    int unsigned                  tok_len;
    logic [7:0]                   wq [3];
    int unsigned                  wn;

    function automatic bit is_letter(logic [7:0] x);
        return (x >= clt_pkg::CH_LA && x <= clt_pkg::CH_LZ)
            || (x >= clt_pkg::CH_UA && x <= clt_pkg::CH_UZ);
    endfunction

    function automatic bit is_digit(logic [7:0] x);
        return x >= clt_pkg::CH_0 && x <= clt_pkg::CH_9;
    endfunction

    function automatic bit is_blank(logic [7:0] x);
        return x == clt_pkg::CH_SPACE || (x >= clt_pkg::CH_TAB && x <= clt_pkg::CH_CR);
    endfunction

    function automatic void lexer_reset();
        la_bytes[0] = '0;
        la_bytes[1] = '0;
        la_count = 0;
        scan_st = clt_pkg::MODE_IDLE;
        quote_ch = '0;
        tok_start = '0;
        byte_pos = '0;
        halted = 1'b0;
        tok_len = 0;
        wn = 0;
    endfunction

    function automatic void emit_tok(clt_pkg::tok_kind_t k, logic [15:0] st, int unsigned ln);
        tok_exp_t t;
        if (step_toks.size() >= 3)
            return;
        t.kind = k;
        t.start = st;
        t.length = (ln > 65535) ? 16'hFFFF : ln[15:0];
        t.lor = 1'b0;
        t.lot = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic void shift_out(int unsigned k);
        if (k > wn)
            k = wn;
        for (int i = 0; i < 3; i++)
            wq[i] = (i + k < 3) ? wq[i + k] : 8'h00;
        wn -= k;
    endfunction

    function automatic int pair(logic [7:0] a, logic [7:0] s, clt_pkg::tok_kind_t two,
                                clt_pkg::tok_kind_t one, output int len);
        if (a == s) begin
            len = 2;
            return two;
        end
        len = 1;
        return one;
    endfunction

    // Punctuator at x with the next two bytes; -1 when x starts none.
    function automatic int punct_kind(logic [7:0] x, logic [7:0] a, logic [7:0] b,
                                      output int len);
        len = 1;
        case (x)
            clt_pkg::CH_PLUS: begin
                if (a == clt_pkg::CH_PLUS) begin len = 2; return clt_pkg::TK_INC; end
                return pair(a, clt_pkg::CH_EQUAL, clt_pkg::TK_PLUS_EQ, clt_pkg::TK_PLUS, len);
            end
            clt_pkg::CH_MINUS: begin
                if (a == clt_pkg::CH_MINUS) begin len = 2; return clt_pkg::TK_DEC; end
                if (a == clt_pkg::CH_EQUAL) begin len = 2; return clt_pkg::TK_MINUS_EQ; end
                return pair(a, clt_pkg::CH_GT, clt_pkg::TK_ARROW, clt_pkg::TK_MINUS, len);
            end
            clt_pkg::CH_STAR:
                return pair(a, clt_pkg::CH_EQUAL, clt_pkg::TK_STAR_EQ, clt_pkg::TK_STAR, len);
            clt_pkg::CH_SLASH:
                return pair(a, clt_pkg::CH_EQUAL, clt_pkg::TK_SLASH_EQ, clt_pkg::TK_SLASH, len);
            clt_pkg::CH_PERCENT:
                return pair(a, clt_pkg::CH_EQUAL, clt_pkg::TK_PERCENT_EQ,
                            clt_pkg::TK_PERCENT, len);
            clt_pkg::CH_EQUAL:
                return pair(a, clt_pkg::CH_EQUAL, clt_pkg::TK_EQ, clt_pkg::TK_ASSIGN, len);
            clt_pkg::CH_BANG:
                return pair(a, clt_pkg::CH_EQUAL, clt_pkg::TK_NE, clt_pkg::TK_NOT, len);
            clt_pkg::CH_LT: begin
                if (a == clt_pkg::CH_LT && b == clt_pkg::CH_EQUAL) begin
                    len = 3;
                    return clt_pkg::TK_SHL_EQ;
                end
                if (a == clt_pkg::CH_EQUAL && b == clt_pkg::CH_GT) begin
                    len = 3;
                    return clt_pkg::TK_SPACESHIP;
                end
                if (a == clt_pkg::CH_LT) begin len = 2; return clt_pkg::TK_SHL; end
                return pair(a, clt_pkg::CH_EQUAL, clt_pkg::TK_LE, clt_pkg::TK_LT, len);
            end
            clt_pkg::CH_GT: begin
                if (a == clt_pkg::CH_GT && b == clt_pkg::CH_EQUAL) begin
                    len = 3;
                    return clt_pkg::TK_SHR_EQ;
                end
                if (a == clt_pkg::CH_GT) begin len = 2; return clt_pkg::TK_SHR; end
                return pair(a, clt_pkg::CH_EQUAL, clt_pkg::TK_GE, clt_pkg::TK_GT, len);
            end
            clt_pkg::CH_TILDE: return clt_pkg::TK_TILDE;
            clt_pkg::CH_AMP: begin
                if (a == clt_pkg::CH_AMP) begin len = 2; return clt_pkg::TK_LAND; end
                return pair(a, clt_pkg::CH_EQUAL, clt_pkg::TK_AMP_EQ, clt_pkg::TK_AMP, len);
            end
            clt_pkg::CH_PIPE: begin
                if (a == clt_pkg::CH_PIPE) begin len = 2; return clt_pkg::TK_LOR; end
                return pair(a, clt_pkg::CH_EQUAL, clt_pkg::TK_PIPE_EQ, clt_pkg::TK_PIPE, len);
            end
            clt_pkg::CH_CARET:
                return pair(a, clt_pkg::CH_EQUAL, clt_pkg::TK_CARET_EQ, clt_pkg::TK_CARET, len);
            clt_pkg::CH_DOT: begin
                if (a == clt_pkg::CH_DOT && b == clt_pkg::CH_DOT) begin
                    len = 3;
                    return clt_pkg::TK_ELLIPSIS;
                end
                return clt_pkg::TK_DOT;
            end
            clt_pkg::CH_COLON:
                return pair(a, clt_pkg::CH_COLON, clt_pkg::TK_SCOPE, clt_pkg::TK_COLON, len);
            clt_pkg::CH_QUEST:
                return pair(a, clt_pkg::CH_COLON, clt_pkg::TK_ELVIS, clt_pkg::TK_QUEST, len);
            clt_pkg::CH_LPAREN: return clt_pkg::TK_LPAREN;
            clt_pkg::CH_RPAREN: return clt_pkg::TK_RPAREN;
            clt_pkg::CH_LBRACK: return clt_pkg::TK_LBRACK;
            clt_pkg::CH_RBRACK: return clt_pkg::TK_RBRACK;
            clt_pkg::CH_LBRACE: return clt_pkg::TK_LBRACE;
            clt_pkg::CH_RBRACE: return clt_pkg::TK_RBRACE;
            clt_pkg::CH_SEMI:   return clt_pkg::TK_SEMI;
            clt_pkg::CH_COMMA:  return clt_pkg::TK_COMMA;
            default:            return -1;
        endcase
    endfunction

    // Bytes of lookahead needed to settle the punctuator at x.
    function automatic int look_depth(logic [7:0] x, logic [7:0] a);
        case (x)
            clt_pkg::CH_TILDE, clt_pkg::CH_LPAREN, clt_pkg::CH_RPAREN, clt_pkg::CH_LBRACK,
            clt_pkg::CH_RBRACK, clt_pkg::CH_LBRACE, clt_pkg::CH_RBRACE, clt_pkg::CH_SEMI,
            clt_pkg::CH_COMMA: return 0;
            clt_pkg::CH_LT:  return (a == clt_pkg::CH_LT || a == clt_pkg::CH_EQUAL) ? 2 : 1;
            clt_pkg::CH_GT:  return (a == clt_pkg::CH_GT) ? 2 : 1;
            clt_pkg::CH_DOT: return (a == clt_pkg::CH_DOT) ? 2 : 1;
            default:         return 1;
        endcase
    endfunction

    function automatic void start_tok(clt_pkg::mode_t m, logic [clt_pkg::POS_BITS-1:0] st,
                                      int unsigned k);
        scan_st = m;
        tok_start = st;
        tok_len = k;
        shift_out(k);
    endfunction

    function automatic void scan_pending(bit fin);
        logic [7:0]                   x;
        logic [7:0]                   a;
        logic [7:0]                   b;
        bit                           have1;
        bit                           have2;
        bit                           ext;
        bit                           close;
        logic [clt_pkg::POS_BITS-1:0] front;
        int                           plen;
        int                           k;
        clt_pkg::tok_kind_t           mk;
        while (1) begin
            if (halted) begin
                wn = 0;
                return;
            end
            if (scan_st != clt_pkg::MODE_IDLE) begin
                mk = (scan_st == clt_pkg::MODE_WORD) ? clt_pkg::TK_WORD :
                     (scan_st == clt_pkg::MODE_NUMBER) ? clt_pkg::TK_NUMBER
                                                       : clt_pkg::TK_STRING;
                if (wn == 0) begin
                    if (fin) begin
                        emit_tok(mk, tok_start, tok_len);
                        scan_st = clt_pkg::MODE_IDLE;
                    end
                    return;
                end
                x = wq[0];
                close = 1'b0;
                if (scan_st == clt_pkg::MODE_WORD)
                    ext = is_letter(x) || is_digit(x) || x == clt_pkg::CH_UNDER;
                else if (scan_st == clt_pkg::MODE_NUMBER)
                    ext = is_letter(x) || is_digit(x) || x == clt_pkg::CH_DOT;
                else begin
                    ext = 1'b1;
                    close = (x == quote_ch);
                end
                if (ext) begin
                    if (tok_len < 65535)
                        tok_len++;
                    shift_out(1);
                    if (close) begin
                        emit_tok(mk, tok_start, tok_len);
                        scan_st = clt_pkg::MODE_IDLE;
                    end
                end else begin
                    emit_tok(mk, tok_start, tok_len);
                    scan_st = clt_pkg::MODE_IDLE;
                end
            end else begin
                if (wn == 0)
                    return;
                front = clt_pkg::POS_BITS'(byte_pos - wn);
                x = wq[0];
                a = (wn > 1) ? wq[1] : 8'h00;
                b = (wn > 2) ? wq[2] : 8'h00;
                have1 = (wn > 1) || fin;
                have2 = (wn > 2) || fin;
                if (is_blank(x))
                    shift_out(1);
                else if (is_letter(x))
                    start_tok(clt_pkg::MODE_WORD, front, 1);
                else if (is_digit(x))
                    start_tok(clt_pkg::MODE_NUMBER, front, 1);
                else if (x == clt_pkg::CH_DQUOTE || x == clt_pkg::CH_SQUOTE) begin
                    quote_ch = x;
                    start_tok(clt_pkg::MODE_STRING, front, 1);
                end else if (punct_kind(x, 8'h00, 8'h00, plen) < 0) begin
                    emit_tok(clt_pkg::TK_ERROR, front, 1);
                    halted = 1'b1;
                    wn = 0;
                    return;
                end else if (look_depth(x, 8'h00) >= 1 && !have1)
                    return;
                else if (x == clt_pkg::CH_DOT && is_digit(a))
                    start_tok(clt_pkg::MODE_NUMBER, front, 2);
                else if (look_depth(x, a) == 2 && !have2)
                    return;
                else begin
                    k = punct_kind(x, a, b, plen);
                    emit_tok(clt_pkg::tok_kind_t'(k), front, plen);
                    shift_out(plen);
                end
            end
        end
    endfunction

    // Tokens expected from one accepted byte, appended to expected_tokens.
    function automatic void lex_byte(logic [7:0] c, logic eot);
        bit ending;
        int n;
        ending = (c == clt_pkg::CH_NUL) || eot;
        step_toks.delete();
        wn = (la_count > 2) ? 2 : la_count;
        for (int i = 0; i < 3; i++)
            wq[i] = (i < wn) ? la_bytes[i] : 8'h00;
        if (!halted && c != clt_pkg::CH_NUL) begin
            wq[wn] = c;
            wn++;
            byte_pos++;
        end
        scan_pending(ending);
        if (c == clt_pkg::CH_NUL || (ending && step_toks.size() == 0))
            emit_tok(clt_pkg::TK_END, byte_pos, 0);
        n = step_toks.size();
        if (n > 0) begin
            step_toks[n - 1].lor = 1'b1;
            if (ending)
                step_toks[n - 1].lot = 1'b1;
        end
        if (ending)
            lexer_reset();
        else begin
            la_count = (wn > 2) ? 2 : wn;
            la_bytes[0] = wq[0];
            la_bytes[1] = wq[1];
        end
        foreach (step_toks[i])
            expected_tokens.push_back(step_toks[i]);
    endfunction

    // Byte source: one transaction per accepted byte, predicted on acceptance.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            chars_if.valid <= 1'b0;
            chars_if.text_byte <= '0;
            chars_if.end_of_text <= 1'b0;
        end else begin
            if (chars_if.valid && chars_if.ready)
                lex_byte(chars_if.text_byte, chars_if.end_of_text);
            if (!chars_if.valid || chars_if.ready) begin
                if (text_backlog.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = text_backlog.pop_front();
                    chars_if.valid <= 1'b1;
                    chars_if.text_byte <= nxt.text_byte;
                    chars_if.end_of_text <= nxt.end_of_text;
                end else
                    chars_if.valid <= 1'b0;
            end
        end
    end

    // Token sink and checker.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            tokens_if.ready <= 1'b0;
        else begin
            if (tokens_if.valid && tokens_if.ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token: kind %0d start %0d length %0d",
                           tokens_if.token_kind, tokens_if.token_start, tokens_if.token_length);
                    fails++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (tokens_if.token_kind !== want.kind) begin
                        $error("token_kind: expected %0d, actual %0d",
                               want.kind, tokens_if.token_kind);
                        fails++;
                    end
                    if (tokens_if.token_start !== want.start) begin
                        $error("token_start: expected %0d, actual %0d",
                               want.start, tokens_if.token_start);
                        fails++;
                    end
                    if (tokens_if.token_length !== want.length) begin
                        $error("token_length: expected %0d, actual %0d",
                               want.length, tokens_if.token_length);
                        fails++;
                    end
                    if (tokens_if.last_of_run !== want.lor) begin
                        $error("last_of_run: expected %0d, actual %0d",
                               want.lor, tokens_if.last_of_run);
                        fails++;
                    end
                    if (tokens_if.last_of_text !== want.lot) begin
                        $error("last_of_text: expected %0d, actual %0d",
                               want.lot, tokens_if.last_of_text);
                        fails++;
                    end
                end
            end
            tokens_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic void push_byte(logic [7:0] b, logic e);
        clt_pkg::item_t it;
        it.text_byte = b;
        it.end_of_text = e;
        text_backlog.push_back(it);
    endfunction

    function automatic void push_str(string s, bit eot_last);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], eot_last && (i == s.len() - 1));
    endfunction

    // Letter or digit, otherwise the given extra byte.
    function automatic logic [7:0] body_char(logic [7:0] extra);
        int r;
        r = $urandom_range(63);
        if (r < 26)
            return clt_pkg::CH_LA + 8'(r);
        if (r < 52)
            return clt_pkg::CH_UA + 8'(r - 26);
        if (r < 62)
            return clt_pkg::CH_0 + 8'(r - 52);
        return extra;
    endfunction

    // One random text, mostly well-formed tokens; returns the bytes queued.
    function automatic int add_random_text();
        logic [7:0] txt [$];
        logic [7:0] q;
        logic [7:0] ch;
        string      p;
        int         sel;
        bit         noisy;
        bit         zero_end;
        noisy = ($urandom_range(9) == 0);
        repeat ($urandom_range(8, 1)) begin
            sel = $urandom_range(99);
            if (noisy && sel < 30)
                txt.push_back(8'($urandom_range(255)));
            else if (sel < 25) begin
                txt.push_back(($urandom_range(1) != 0)
                              ? clt_pkg::CH_LA + 8'($urandom_range(25))
                              : clt_pkg::CH_UA + 8'($urandom_range(25)));
                repeat ($urandom_range(7)) txt.push_back(body_char(clt_pkg::CH_UNDER));
            end else if (sel < 40) begin
                if ($urandom_range(3) == 0)
                    txt.push_back(clt_pkg::CH_DOT);
                txt.push_back(clt_pkg::CH_0 + 8'($urandom_range(9)));
                repeat ($urandom_range(5)) txt.push_back(body_char(clt_pkg::CH_DOT));
            end else if (sel < 50) begin
                q = ($urandom_range(1) != 0) ? clt_pkg::CH_DQUOTE : clt_pkg::CH_SQUOTE;
                txt.push_back(q);
                repeat ($urandom_range(6)) begin
                    ch = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 1))
                                                  : body_char(clt_pkg::CH_SPACE);
                    txt.push_back((ch == q) ? clt_pkg::CH_LA : ch);
                end
                // now and then left open to run to the end of the text
                if ($urandom_range(9) != 0)
                    txt.push_back(q);
            end else begin
                p = punct_list[$urandom_range(48)];
                for (int i = 0; i < p.len(); i++)
                    txt.push_back(p[i]);
            end
            case ($urandom_range(3))
                0: ;
                3: txt.push_back(clt_pkg::CH_TAB + 8'($urandom_range(4)));
                default: txt.push_back(clt_pkg::CH_SPACE);
            endcase
        end
        zero_end = ($urandom_range(9) == 0);
        foreach (txt[i])
            push_byte(txt[i], !zero_end && (i == txt.size() - 1));
        if (zero_end)
            push_byte(clt_pkg::CH_NUL, 1'($urandom_range(1)));
        return txt.size() + int'(zero_end);
    endfunction

    initial begin
        int queued;
        rst_n = 1'b0;
        src_idle_pct = 19;
        snk_idle_pct = 72;
        lexer_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin src_idle_pct = 19; snk_idle_pct = 72; end
                1: begin src_idle_pct = 72; snk_idle_pct = 19; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            if (ph == 0) begin
                push_str("ab_9", 1'b1);
                push_byte(clt_pkg::CH_NUL, 1'b0);  // zero byte, nothing pending
                push_str("<", 1'b0);               // lookahead flushed by zero byte
                push_byte(clt_pkg::CH_NUL, 1'b0);
                push_str("..", 1'b1);
                push_str("_xy", 1'b1);             // leading underscore halts
                push_str("'ab", 1'b1);             // string left open
                push_byte(8'hFF, 1'b0);
                push_byte(clt_pkg::CH_NUL, 1'b1);
                push_str("<=>", 1'b1);
                push_str(" ", 1'b1);               // end flag after a blank: only the end token
                push_str(".5", 1'b1);
                for (int i = 0; i < 49; i++) begin
                    push_str(punct_list[i], 1'b0);
                    push_byte(clt_pkg::CH_SPACE, i == 48);
                end
            end
            queued = 0;
            while (queued < 80)
                queued += add_random_text();
            // hold the source until every token of this phase is back
            while (text_backlog.size() != 0 || chars_if.valid || expected_tokens.size() != 0)
                @(negedge clk);
        end

        repeat (10) @(negedge clk);
        if (fails == 0 && expected_tokens.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
